FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks clocked on aclk, held off while aresetn is low
`define MTCG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define MTCG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/mtcg_pkg.sv
package mtcg_pkg;

    localparam int RPM_W      = 14;
    localparam int TEETH_W    = 7;
    localparam int POS_W      = 8;
    localparam int PERIOD_W   = 24;
    localparam int PROD_W     = RPM_W + TEETH_W;
    localparam int DEN_W      = PROD_W + 1;
    localparam int DIVIDEND_W = 26;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    localparam int MAX_TEETH = 127;
    localparam int MIN_TEETH = 2;

    localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = 26'd60000000;

    localparam logic [CFG_IDX_W-1:0] REG_RPM     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEETH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING = 2'd2;

    localparam logic [RPM_W-1:0]   RPM_RESET     = 14'd0;
    localparam logic [TEETH_W-1:0] TEETH_RESET   = 7'd60;
    localparam logic [TEETH_W-1:0] MISSING_RESET = 7'd2;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic [TEETH_W-1:0] eff_teeth(input logic [TEETH_W-1:0] t);
        logic [TEETH_W-1:0] r;
        r = t;
        if (t < TEETH_W'(MIN_TEETH)) begin
            r = TEETH_W'(MIN_TEETH);
        end else if (t > TEETH_W'(MAX_TEETH)) begin
            r = TEETH_W'(MAX_TEETH);
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/mtcg_div.sv
module mtcg_div import mtcg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;

    // one restoring step per cycle, msb first
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = (trial >= {1'b0, den_reg});
    assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            den_reg <= req.divisor;
            quo_reg <= US_PER_MINUTE;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/missing_tooth_crank_generator_unit.sv
// a result is registered in the cycle after its transaction is accepted
// throughput: one transaction per cycle while idle and the result side takes them
// a register write to index 0, 1 or 2 holds s_ready low, and unless rpm is 0 also
// while the shared bit-serial divider works out the half-tooth period (26 quotient bits)
// reset: synchronous, active low; rpm 0, 60 teeth, 2 missing, generator stopped
`include "assert_macros.svh"

module missing_tooth_crank_generator_unit import mtcg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_advance,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_crank_level,
    output logic [POS_W-1:0]      m_half_tooth_index,
    output logic                  m_step_taken,
    output logic                  m_revolution_start
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_START = 2'd2;
    localparam logic [1:0] ST_WAIT  = 2'd3;

    logic [1:0]          st_reg;
    logic [RPM_W-1:0]    rpm_reg;
    logic [TEETH_W-1:0]  teeth_reg;
    logic [TEETH_W-1:0]  missing_reg;
    logic [PERIOD_W-1:0] hp_reg;
    logic [PERIOD_W-1:0] tick_reg;
    logic [POS_W-1:0]    pos_reg;
    logic                level_reg;
    logic [DEN_W-1:0]    den_reg;

    logic                m_valid_reg;
    logic                level_out_reg;
    logic [POS_W-1:0]    pos_out_reg;
    logic                step_out_reg;
    logic                rev_out_reg;

    logic [PERIOD_W-1:0] tick_next;
    logic [POS_W-1:0]    pos_next;
    logic                level_next;

    logic                accept;
    logic                cfg_hit;
    logic [TEETH_W-1:0]  teeth_eff;
    logic [POS_W-1:0]    wrap_at;
    logic [POS_W-1:0]    live_limit;
    logic                gap_ok;
    logic [PERIOD_W-1:0] tick_inc;
    logic                run;
    logic                hit;
    logic [POS_W:0]      pos_inc;
    logic                wrap;
    logic [PROD_W-1:0]   rt_prod;
    logic [DEN_W-1:0]    den_calc;
    logic [PERIOD_W-1:0] hp_calc;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign accept  = s_valid && s_ready;
    assign cfg_hit = cfg_wr_en && ((cfg_wr_idx == REG_RPM) || (cfg_wr_idx == REG_TEETH)
                                   || (cfg_wr_idx == REG_MISSING));

    assign teeth_eff  = eff_teeth(teeth_reg);
    assign wrap_at    = {teeth_eff, 1'b0};
    assign live_limit = {teeth_eff - missing_reg, 1'b0};
    assign gap_ok     = (missing_reg < teeth_eff);

    assign tick_inc = tick_reg + 1'b1;
    assign run      = s_advance && (rpm_reg != '0) && (hp_reg != '0);
    assign hit      = run && (tick_inc >= hp_reg);
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign wrap     = (pos_inc >= {1'b0, wrap_at});

    always_comb begin
        tick_next  = tick_reg;
        pos_next   = pos_reg;
        level_next = level_reg;
        if (hit) begin
            tick_next  = '0;
            pos_next   = wrap ? '0 : pos_inc[POS_W-1:0];
            level_next = level_reg ^ (gap_ok && (pos_reg < live_limit));
        end else if (run) begin
            tick_next = tick_inc;
        end
    end

    // speed times teeth times two
    assign rt_prod  = PROD_W'(rpm_reg) * PROD_W'(teeth_eff);
    assign den_calc = {rt_prod, 1'b0};

    assign hp_calc = (div_rsp.quotient == '0) ? PERIOD_W'(1)
                                              : div_rsp.quotient[PERIOD_W-1:0];

    assign div_req.start   = (st_reg == ST_START);
    assign div_req.divisor = den_reg;

    mtcg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            rpm_reg     <= RPM_RESET;
            teeth_reg   <= TEETH_RESET;
            missing_reg <= MISSING_RESET;
            hp_reg      <= '0;
            tick_reg    <= '0;
            pos_reg     <= '0;
            level_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end
            if (cfg_hit) begin
                unique case (cfg_wr_idx)
                    REG_RPM:     rpm_reg     <= cfg_wr_data[RPM_W-1:0];
                    REG_TEETH:   teeth_reg   <= cfg_wr_data[TEETH_W-1:0];
                    default:     missing_reg <= cfg_wr_data[TEETH_W-1:0];
                endcase
                tick_reg <= '0;
                st_reg   <= ST_MUL;
            end else begin
                unique case (st_reg)
                    ST_IDLE: begin
                        if (accept) begin
                            tick_reg  <= tick_next;
                            pos_reg   <= pos_next;
                            level_reg <= level_next;
                        end
                    end
                    ST_MUL: begin
                        if (rpm_reg == '0) begin
                            hp_reg <= '0;
                            st_reg <= ST_IDLE;
                        end else begin
                            st_reg <= ST_START;
                        end
                    end
                    ST_START: begin
                        st_reg <= ST_WAIT;
                    end
                    default: begin
                        if (div_rsp.done) begin
                            hp_reg <= hp_calc;
                            st_reg <= ST_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_reg == ST_MUL) begin
            den_reg <= den_calc;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            level_out_reg <= level_next;
            pos_out_reg   <= pos_next;
            step_out_reg  <= hit;
            rev_out_reg   <= hit && wrap;
        end
    end

    assign s_ready            = (st_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid            = m_valid_reg;
    assign m_crank_level      = level_out_reg;
    assign m_half_tooth_index = pos_out_reg;
    assign m_step_taken       = step_out_reg;
    assign m_revolution_start = rev_out_reg;

    `MTCG_ASSERT_IMPL(a_rev_on_step, m_valid && m_revolution_start, m_step_taken && (m_half_tooth_index == '0))
    `MTCG_ASSERT_NEXT(a_cfg_blocks_input, cfg_hit, !s_ready)
    `MTCG_ASSERT_IMPL(a_ready_only_idle, s_ready, st_reg == ST_IDLE)
    `MTCG_ASSERT_IMPL(a_index_on_wheel, m_valid, m_half_tooth_index < 8'd254)

endmodule

FILE: verif/missing_tooth_crank_generator_unit_tb.sv
`timescale 1ns / 100ps

module missing_tooth_crank_generator_unit_tb;
    import mtcg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 40;
    localparam int DIR_ROWS       = 28;
    localparam int unsigned MINUTE_US = 60000000;

    typedef struct packed {
        logic             level;
        logic [POS_W-1:0] index;
        logic             stepped;
        logic             wrapped;
    } crank_obs_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  adv;
        logic                  known;
        crank_obs_t            want;
    } dir_row_t;

    localparam crank_obs_t WHEEL_AT_REST = '0;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_advance   = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_crank_level;
    logic [POS_W-1:0]      m_half_tooth_index;
    logic                  m_step_taken;
    logic                  m_revolution_start;

    // marks a directed transaction whose result is typed in the table
    logic                  known_armed = 1'b0;
    crank_obs_t            known_want  = '0;

    int  tx_gap_pct   = 0;
    int  rx_stall_pct = 0;
    bit  rx_hold_req  = 1'b0;

    int  errors   = 0;
    int  n_ticks  = 0;
    int  n_writes = 0;
    int  n_steps  = 0;
    int  n_wraps  = 0;

    // wheel model state
    logic [RPM_W-1:0]    rpm_q;
    logic [TEETH_W-1:0]  teeth_q;
    logic [TEETH_W-1:0]  missing_q;
    logic [PERIOD_W-1:0] half_period_q;
    logic [PERIOD_W-1:0] tick_q;
    logic [POS_W-1:0]    pos_q;
    logic                level_q;

    crank_obs_t pending_crank_q [$];
    dir_row_t   dir_rows [0:DIR_ROWS-1];

    missing_tooth_crank_generator_unit dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_idx         (cfg_wr_idx),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_advance          (s_advance),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_crank_level      (m_crank_level),
        .m_half_tooth_index (m_half_tooth_index),
        .m_step_taken       (m_step_taken),
        .m_revolution_start (m_revolution_start)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned wheel_teeth(input logic [TEETH_W-1:0] t);
        int unsigned r;
        r = t;
        if (r < MIN_TEETH) begin
            r = MIN_TEETH;
        end else if (r > MAX_TEETH) begin
            r = MAX_TEETH;
        end
        return r;
    endfunction

    task automatic recompute_half_period();
        int unsigned den;
        int unsigned q;
        if (rpm_q == '0) begin
            half_period_q = '0;
        end else begin
            den = 32'(rpm_q) * wheel_teeth(teeth_q) * 2;
            q = MINUTE_US / den;
            if (q < 1) begin
                q = 1;
            end
            half_period_q = q[PERIOD_W-1:0];
        end
    endtask

    task automatic reset_wheel_model();
        rpm_q     = RPM_RESET;
        teeth_q   = TEETH_RESET;
        missing_q = MISSING_RESET;
        tick_q    = '0;
        pos_q     = '0;
        level_q   = 1'b0;
        recompute_half_period();
    endtask

    task automatic apply_wheel_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_RPM: begin
                rpm_q = data[RPM_W-1:0];
            end
            REG_TEETH: begin
                teeth_q = data[TEETH_W-1:0];
            end
            REG_MISSING: begin
                missing_q = data[TEETH_W-1:0];
            end
            default: begin
                return;
            end
        endcase
        tick_q = '0;
        recompute_half_period();
    endtask

    task automatic turn_wheel(input logic adv, output crank_obs_t r);
        int unsigned teeth;
        int unsigned pos_next;
        logic        stepped;
        logic        wrapped;
        stepped = 1'b0;
        wrapped = 1'b0;
        if (adv && rpm_q != '0 && half_period_q != '0) begin
            teeth  = wheel_teeth(teeth_q);
            tick_q = tick_q + 1'b1;
            if (tick_q >= half_period_q) begin
                tick_q  = '0;
                stepped = 1'b1;
                if (missing_q < teeth && pos_q < (teeth - missing_q) * 2) begin
                    level_q = ~level_q;
                end
                pos_next = pos_q + 1;
                if (pos_next >= teeth * 2) begin
                    pos_next = 0;
                    wrapped  = 1'b1;
                end
                pos_q = pos_next[POS_W-1:0];
            end
        end
        r = '{level_q, pos_q, stepped, wrapped};
    endtask

    task automatic note_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
        end
    endtask

    // model update on writes and accepted ticks, result checking
    always @(posedge aclk) begin
        crank_obs_t pred;
        crank_obs_t want;
        crank_obs_t got;
        if (aresetn) begin
            if (cfg_wr_en) begin
                apply_wheel_write(cfg_wr_idx, cfg_wr_data);
                n_writes++;
            end
            if (s_valid && s_ready) begin
                turn_wheel(s_advance, pred);
                pending_crank_q.push_back(known_armed ? known_want : pred);
                n_ticks++;
            end
            if (m_valid && m_ready) begin
                got = '{m_crank_level, m_half_tooth_index, m_step_taken,
                        m_revolution_start};
                if (pending_crank_q.size() == 0) begin
                    note_mismatch("result transaction with nothing pending");
                end else begin
                    want = pending_crank_q.pop_front();
                    check_field("crank_level", POS_W'(want.level), POS_W'(got.level));
                    check_field("half_tooth_index", want.index, got.index);
                    check_field("step_taken", POS_W'(want.stepped), POS_W'(got.stepped));
                    check_field("revolution_start", POS_W'(want.wrapped),
                                POS_W'(got.wrapped));
                end
                if (got.stepped === 1'b1) begin
                    n_steps++;
                end
                if (got.wrapped === 1'b1) begin
                    n_wraps++;
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_tick(input logic adv, input logic known, input crank_obs_t want);
        while ($urandom_range(99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_advance   <= adv;
        known_armed <= known;
        known_want  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (!s_ready || pending_crank_q.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic dir_row_t tick_row(input logic adv);
        return '{ROW_TICK, REG_RPM, '0, adv, 1'b0, '0};
    endfunction

    function automatic dir_row_t known_row(input logic adv, input crank_obs_t want);
        return '{ROW_TICK, REG_RPM, '0, adv, 1'b1, want};
    endfunction

    function automatic dir_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        return '{ROW_WRITE, idx, data, 1'b0, 1'b0, '0};
    endfunction

    initial begin
        int         n_items;
        int         adv_pct;
        logic [6:0] junk;
        reset_wheel_model();

        // stopped wheel after reset, ignored register, then fastest full wheel
        dir_rows[0] = known_row(1'b0, WHEEL_AT_REST);
        dir_rows[1] = known_row(1'b1, WHEEL_AT_REST);
        dir_rows[2] = write_row(REG_UNUSED, 14'h3fff);
        dir_rows[3] = known_row(1'b1, WHEEL_AT_REST);
        dir_rows[4] = write_row(REG_TEETH, 14'h3fff);
        dir_rows[5] = write_row(REG_MISSING, 14'd0);
        dir_rows[6] = write_row(REG_RPM, 14'h3fff);
        for (int i = 7; i < 20; i++) begin
            dir_rows[i] = tick_row(1'b1);
        end
        dir_rows[20] = tick_row(1'b0);
        dir_rows[21] = tick_row(1'b1);
        // gap as wide as the wheel, tooth count below range, slowest speed
        dir_rows[22] = write_row(REG_MISSING, 14'd127);
        dir_rows[23] = write_row(REG_TEETH, 14'd0);
        dir_rows[24] = write_row(REG_RPM, 14'd1);
        for (int i = 25; i < DIR_ROWS; i++) begin
            dir_rows[i] = tick_row(1'b1);
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                cfg_write(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_tick(dir_rows[i].adv, dir_rows[i].known, dir_rows[i].want);
            end
        end

        for (int phase = 0; phase < 5; phase++) begin
            adv_pct = 94;
            junk    = 7'($urandom);
            case (phase)
                0: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                    n_items      = 150;
                    cfg_write(REG_TEETH, {junk, 7'd127});
                    cfg_write(REG_MISSING, 14'd124);
                    cfg_write(REG_RPM, 14'h3fff);
                end
                1: begin
                    tx_gap_pct   = 56;
                    rx_stall_pct = 0;
                    n_items      = 150;
                    cfg_write(REG_MISSING, {junk, 7'($urandom_range(20))});
                end
                2: begin
                    // fewer teeth than the index has reached, so it wraps
                    tx_gap_pct   = 0;
                    rx_stall_pct = 56;
                    n_items      = 180;
                    cfg_write(REG_TEETH, 14'd9);
                    rx_hold_req  = 1'b1;
                end
                3: begin
                    tx_gap_pct   = 30;
                    rx_stall_pct = 30;
                    n_items      = 60;
                    adv_pct      = 50;
                    cfg_write(REG_RPM, 14'd0);
                end
                default: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                    n_items      = 90;
                    cfg_write(REG_TEETH, {junk, 7'($urandom_range(127))});
                    cfg_write(REG_MISSING, 14'($urandom));
                    cfg_write(REG_RPM, ($urandom_range(99) < 20) ?
                              14'($urandom) : 14'($urandom_range(16383, 9000)));
                end
            endcase
            for (int k = 0; k < n_items; k++) begin
                send_tick($urandom_range(99) < adv_pct, 1'b0, '0);
            end
        end

        s_valid      <= 1'b0;
        rx_stall_pct = 0;
        while (pending_crank_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d tick transactions over %0d register writes", n_ticks, n_writes);
        $display("%0d half-tooth steps and %0d revolution starts seen", n_steps, n_wraps);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
